@@ design/crs_pkg.sv @@
package crs_pkg;

    localparam int COORD_W = 32;
    localparam int T_FRAC  = 16;
    localparam int T_W     = T_FRAC + 1;
    // wide enough for every intermediate of both modes with margin
    localparam int ACC_W   = 48;
    localparam int PROD_W  = ACC_W + T_W + 1;

    typedef enum logic
    {
        OP_POSITION = 1'b0,
        OP_TANGENT  = 1'b1
    } op_t;

    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [T_W-1:0]            tpar_t;

    typedef struct packed
    {
        op_t    op;
        tpar_t  t;
        acc_t   mul_x;
        acc_t   add_y;
        acc_t   c2;
        coord_t p2;
    } coef_word_t;

    typedef struct packed
    {
        op_t    op;
        tpar_t  t;
        acc_t   add_y;
        acc_t   c2;
        coord_t p2;
        prod_t  prod;
    } mul1_word_t;

    typedef struct packed
    {
        op_t    op;
        tpar_t  t;
        acc_t   c2;
        coord_t p2;
        prod_t  prod;
    } mul2_word_t;

    typedef struct packed
    {
        op_t    op;
        acc_t   v;
        coord_t p2;
        prod_t  prod;
    } mul3_word_t;

    // exact signed product of an accumulator value and the unsigned parameter
    function automatic prod_t mul_by_t(acc_t x, tpar_t t);
        prod_t xe;
        prod_t te;
        xe = PROD_W'(x);
        te = PROD_W'($signed({1'b0, t}));
        return xe * te;
    endfunction

    // floor(x * t / 2^T_FRAC) back to accumulator width
    function automatic acc_t scale_down(prod_t p);
        return $signed(p[T_FRAC +: ACC_W]);
    endfunction

endpackage

@@ design/catmull_rom_spline_eval.sv @@
// Uniform Catmull-Rom evaluator for one coordinate: each word carries four Q16.16 control
// values and t in unsigned Q1.16 (up to just under 2.0), and returns the position or the
// derivative along t in Q16.16, clipped to the 32-bit range with a flag. One word is taken
// every clock while the output is not stalled, and each word passes through the coefficient
// stage, three 48 x 18 bit multiplier stages for the nested form, and the final scale and clip
// register. Back-pressure on the output stalls the stages
// in turn, and ready stays high whenever the output side is ready.
module catmull_rom_spline_eval
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  operation,
    input  logic [16:0]           t_fraction,
    input  logic signed [31:0]    point_before,
    input  logic signed [31:0]    segment_start,
    input  logic signed [31:0]    segment_end,
    input  logic signed [31:0]    point_after,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic signed [31:0]    curve_value,
    output logic                  saturated
);

    logic                coef_valid;
    logic                coef_ready;
    crs_pkg::coef_word_t coef_word;
    logic                horner_valid;
    logic                horner_ready;
    crs_pkg::mul3_word_t horner_word;

    crs_coef u_coef
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (item_valid),
        .up_ready      (item_ready),
        .operation     (crs_pkg::op_t'(operation)),
        .t_fraction    (t_fraction),
        .point_before  (point_before),
        .segment_start (segment_start),
        .segment_end   (segment_end),
        .point_after   (point_after),
        .down_valid    (coef_valid),
        .down_ready    (coef_ready),
        .down_word     (coef_word)
    );

    crs_horner u_horner
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (coef_valid),
        .up_ready   (coef_ready),
        .up_word    (coef_word),
        .down_valid (horner_valid),
        .down_ready (horner_ready),
        .down_word  (horner_word)
    );

    crs_out u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (horner_valid),
        .up_ready   (horner_ready),
        .up_word    (horner_word),
        .down_valid (result_valid),
        .down_ready (result_ready),
        .value      (curve_value),
        .clipped    (saturated)
    );

    // a ready sink never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> item_ready)
        else $error("input stalled while output side ready");

    // a clipped word sits at one of the range limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && saturated) |->
            (curve_value == 32'sh7fff_ffff || curve_value == 32'sh8000_0000))
        else $error("saturated result not at a range limit");

    // the output stage only empties after a handover
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid)
        else $error("result word dropped while stalled");

endmodule

@@ design/crs_coef.sv @@
module crs_coef
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  crs_pkg::op_t         operation,
    input  crs_pkg::tpar_t       t_fraction,
    input  crs_pkg::coord_t      point_before,
    input  crs_pkg::coord_t      segment_start,
    input  crs_pkg::coord_t      segment_end,
    input  crs_pkg::coord_t      point_after,
    output logic                 down_valid,
    input  logic                 down_ready,
    output crs_pkg::coef_word_t  down_word
);

    logic                valid_reg;
    logic                valid_next;
    crs_pkg::coef_word_t word_reg;
    crs_pkg::coef_word_t word_next;

    crs_pkg::acc_t p1;
    crs_pkg::acc_t p2;
    crs_pkg::acc_t p3;
    crs_pkg::acc_t p4;
    crs_pkg::acc_t d23;
    crs_pkg::acc_t a2;
    crs_pkg::acc_t b2;
    crs_pkg::acc_t c2;

    assign p1 = crs_pkg::ACC_W'(point_before);
    assign p2 = crs_pkg::ACC_W'(segment_start);
    assign p3 = crs_pkg::ACC_W'(segment_end);
    assign p4 = crs_pkg::ACC_W'(point_after);

    // doubled coefficients, all exact integers
    assign d23 = p2 - p3;
    assign a2  = (p4 - p1) + (d23 <<< 1) + d23;
    assign b2  = (p1 <<< 1) - (p2 <<< 2) - p2 + (p3 <<< 2) - p4;
    assign c2  = p3 - p1;

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        valid_next    = up_ready ? up_valid : valid_reg;
        word_next.op  = operation;
        word_next.t   = t_fraction;
        word_next.c2  = c2;
        word_next.p2  = segment_start;
        case (operation)
            crs_pkg::OP_TANGENT:
            begin
                word_next.mul_x = (a2 <<< 1) + a2;
                word_next.add_y = b2 <<< 1;
            end
            default:
            begin
                word_next.mul_x = a2;
                word_next.add_y = b2;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_word  = word_reg;

endmodule

@@ design/crs_horner.sv @@
module crs_horner
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  crs_pkg::coef_word_t  up_word,
    output logic                 down_valid,
    input  logic                 down_ready,
    output crs_pkg::mul3_word_t  down_word
);

    logic                va_reg;
    logic                va_next;
    logic                vb_reg;
    logic                vb_next;
    logic                vc_reg;
    logic                vc_next;
    logic                ready_a;
    logic                ready_b;
    logic                ready_c;
    crs_pkg::mul1_word_t wa_reg;
    crs_pkg::mul1_word_t wa_next;
    crs_pkg::mul2_word_t wb_reg;
    crs_pkg::mul2_word_t wb_next;
    crs_pkg::mul3_word_t wc_reg;
    crs_pkg::mul3_word_t wc_next;
    crs_pkg::acc_t       u;
    crs_pkg::acc_t       v;

    assign ready_c  = !vc_reg || down_ready;
    assign ready_b  = !vb_reg || ready_c;
    assign ready_a  = !va_reg || ready_b;
    assign up_ready = ready_a;

    assign va_next = ready_a ? up_valid : va_reg;
    assign vb_next = ready_b ? va_reg : vb_reg;
    assign vc_next = ready_c ? vb_reg : vc_reg;

    // first product: 2a or 6a times t
    always_comb
    begin
        wa_next.op    = up_word.op;
        wa_next.t     = up_word.t;
        wa_next.add_y = up_word.add_y;
        wa_next.c2    = up_word.c2;
        wa_next.p2    = up_word.p2;
        wa_next.prod  = crs_pkg::mul_by_t(up_word.mul_x, up_word.t);
    end

    // second step of the nested form
    assign u = crs_pkg::scale_down(wa_reg.prod) + wa_reg.add_y;

    always_comb
    begin
        wb_next.op   = wa_reg.op;
        wb_next.t    = wa_reg.t;
        wb_next.c2   = wa_reg.c2;
        wb_next.p2   = wa_reg.p2;
        wb_next.prod = crs_pkg::mul_by_t(u, wa_reg.t);
    end

    // third product only matters for position
    assign v = crs_pkg::scale_down(wb_reg.prod) + wb_reg.c2;

    always_comb
    begin
        wc_next.op   = wb_reg.op;
        wc_next.v    = v;
        wc_next.p2   = wb_reg.p2;
        wc_next.prod = crs_pkg::mul_by_t(v, wb_reg.t);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && up_valid)
        begin
            wa_reg <= wa_next;
        end
        if (ready_b && va_reg)
        begin
            wb_reg <= wb_next;
        end
        if (ready_c && vb_reg)
        begin
            wc_reg <= wc_next;
        end
    end

    assign down_valid = vc_reg;
    assign down_word  = wc_reg;

endmodule

@@ design/crs_out.sv @@
module crs_out
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  crs_pkg::mul3_word_t  up_word,
    output logic                 down_valid,
    input  logic                 down_ready,
    output crs_pkg::coord_t      value,
    output logic                 clipped
);

    logic            valid_reg;
    logic            valid_next;
    crs_pkg::coord_t value_reg;
    crs_pkg::coord_t value_next;
    logic            clipped_reg;
    logic            clipped_next;
    crs_pkg::acc_t   pos;
    crs_pkg::acc_t   r;
    logic            in_range;

    // floor(w / 2) folded into the shift of the last product
    assign pos = $signed(up_word.prod[crs_pkg::T_FRAC+1 +: crs_pkg::ACC_W])
                 + crs_pkg::ACC_W'(up_word.p2);

    always_comb
    begin
        case (up_word.op)
            crs_pkg::OP_TANGENT: r = up_word.v >>> 1;
            default:             r = pos;
        endcase
    end

    // in range when all bits above the sign bit agree with it
    assign in_range = (&r[crs_pkg::ACC_W-1:crs_pkg::COORD_W-1])
                   || !(|r[crs_pkg::ACC_W-1:crs_pkg::COORD_W-1]);

    always_comb
    begin
        clipped_next = !in_range;
        if (in_range)
        begin
            value_next = r[crs_pkg::COORD_W-1:0];
        end
        else if (r[crs_pkg::ACC_W-1])
        begin
            value_next = {1'b1, {(crs_pkg::COORD_W-1){1'b0}}};
        end
        else
        begin
            value_next = {1'b0, {(crs_pkg::COORD_W-1){1'b1}}};
        end
    end

    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            value_reg   <= value_next;
            clipped_reg <= clipped_next;
        end
    end

    assign down_valid = valid_reg;
    assign value      = value_reg;
    assign clipped    = clipped_reg;

endmodule
